// ===== design/easter_and_movable_feasts_top_assert.svh =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: assertion macros
// Shared concurrent assertion forms used by the feast calculator RTL.
// ----------------------------------------------------------------------------
`ifndef EASTER_AND_MOVABLE_FEASTS_TOP_ASSERT_SVH
`define EASTER_AND_MOVABLE_FEASTS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/emf_pkg.sv =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: package
// Types, constants and the date conversion helper shared by the pipeline.
// ----------------------------------------------------------------------------
package emf_pkg;

   // Number of register stages from the input to the result register.
   localparam int NUM_STAGES = 8;

   // Reciprocals for the constant divisions. The ones for 100, 19 and 30 are
   // slightly low, so the estimated quotient is exact or one too small; the
   // ones for 25, 3 and 7 are slightly high and exact over the range they see.
   localparam logic [12:0] RECIP_100 = 13'd5242;   // 2^19 / 100
   localparam logic [15:0] RECIP_19  = 16'd55188;  // 2^20 / 19
   localparam logic [5:0]  RECIP_25  = 6'd41;      // 2^10 / 25, exact below 664
   localparam logic [9:0]  RECIP_3   = 10'd683;    // 2^11 / 3, exact below 657
   localparam logic [5:0]  RECIP_30  = 6'd34;      // 2^10 / 30
   localparam logic [5:0]  RECIP_7   = 6'd37;      // 2^8 / 7, exact below 87

   // Month numbers.
   localparam logic [2:0] MON_FEB = 3'd2;
   localparam logic [2:0] MON_MAR = 3'd3;
   localparam logic [2:0] MON_APR = 3'd4;
   localparam logic [2:0] MON_MAY = 3'd5;
   localparam logic [2:0] MON_JUN = 3'd6;

   // Feast offsets in days relative to Easter Sunday.
   localparam logic signed [7:0] CARNIVAL_START_OFS = -8'sd49;
   localparam logic signed [7:0] CARNIVAL_END_OFS   = -8'sd47;
   localparam logic signed [7:0] GOOD_FRIDAY_OFS    = -8'sd2;
   localparam logic signed [7:0] ASCENSION_OFS      = 8'sd39;
   localparam logic signed [7:0] WHITSUN_OFS        = 8'sd49;

   // Computus terms handed from the divider front end to the core.
   typedef struct packed {
      logic [4:0] a;
      logic [9:0] b;
      logic [7:0] d;
      logic [4:0] f;
      logic [1:0] e;
      logic [4:0] i;
      logic [1:0] k;
      logic       leap;
   } div_out_type;

   // Easter Sunday date plus the leap flag for the feast stage.
   typedef struct packed {
      logic [4:0] dom;
      logic [2:0] mon;
      logic       leap;
   } easter_type;

   typedef struct packed {
      logic [4:0] dom;
      logic [2:0] mon;
   } date_type;

   // All result dates of one item.
   typedef struct packed {
      date_type easter;
      date_type carnival_start;
      date_type carnival_end;
      date_type good_friday;
      date_type ascension;
      date_type whitsun;
   } feasts_type;

   // Turns a day offset from March 1 (negative reaches into February)
   // into a day of month and month number.
   function automatic date_type to_date(input logic signed [7:0] offs, input logic leap);
      date_type          res;
      logic signed [7:0] feb_day;
      feb_day = offs + (leap ? 8'sd30 : 8'sd29);
      if (offs < 8'sd0) begin
         res.mon = MON_FEB;
         res.dom = feb_day[4:0];
      end else if (offs < 8'sd31) begin
         res.mon = MON_MAR;
         res.dom = 5'(offs + 8'sd1);
      end else if (offs < 8'sd61) begin
         res.mon = MON_APR;
         res.dom = 5'(offs - 8'sd30);
      end else if (offs < 8'sd92) begin
         res.mon = MON_MAY;
         res.dom = 5'(offs - 8'sd60);
      end else begin
         res.mon = MON_JUN;
         res.dom = 5'(offs - 8'sd91);
      end
      return res;
   endfunction

endpackage

// ===== design/easter_and_movable_feasts_top.sv =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: top level
// Computes Easter Sunday and five movable feasts for a Gregorian year.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one year per item; the rsp channel returns one
// item per year with the day and month of Easter Sunday, Carnival Sunday,
// Carnival Tuesday, Good Friday, Ascension Day and Whitsuntide.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low.
// Throughput is one item per cycle while the receiver does not stall, set by
// the 8-stage pipeline: three divider stages, four computus stages and one
// feast stage whose register drives the rsp ports.
// Each stage keeps its own valid bit, so empty stages close up while the
// receiver stalls and req_stall rises only once all 8 stages hold items.
// A stalled result stays unchanged on the rsp ports until it is taken.
// Reset clears all valid bits; no item is in flight afterwards.
module easter_and_movable_feasts_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_year,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_easter_dom,
   output logic [2:0]  rsp_easter_mon,
   output logic [4:0]  rsp_carnival_start_dom,
   output logic [1:0]  rsp_carnival_start_mon,
   output logic [4:0]  rsp_carnival_end_dom,
   output logic [1:0]  rsp_carnival_end_mon,
   output logic [4:0]  rsp_good_friday_dom,
   output logic [2:0]  rsp_good_friday_mon,
   output logic [4:0]  rsp_ascension_dom,
   output logic [2:0]  rsp_ascension_mon,
   output logic [4:0]  rsp_whitsun_dom,
   output logic [2:0]  rsp_whitsun_mon
);
   import emf_pkg::*;

   `include "easter_and_movable_feasts_top_assert.svh"

   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] stage_en;
   div_out_type           div_out;
   easter_type            easter;
   feasts_type            feasts;

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      stage_en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || !rsp_stall;
      for (int j = NUM_STAGES - 2; j >= 0; j--) begin
         stage_en[j] = !v_ff[j] || stage_en[j+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      v_in[0] = stage_en[0] ? req_valid : v_ff[0];
      for (int j = 1; j < NUM_STAGES; j++) begin
         v_in[j] = stage_en[j] ? v_ff[j-1] : v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = v_ff[NUM_STAGES-1];

   // Datapath.
   emf_div u_div (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .year     (req_year),
      .div_out  (div_out)
   );

   emf_cpt u_cpt (
      .clock    (clock),
      .stage_en (stage_en[6:3]),
      .div_out  (div_out),
      .easter   (easter)
   );

   emf_fst u_fst (
      .clock    (clock),
      .stage_en (stage_en[7]),
      .easter   (easter),
      .feasts   (feasts)
   );

   // Result ports.
   assign rsp_easter_dom         = feasts.easter.dom;
   assign rsp_easter_mon         = feasts.easter.mon;
   assign rsp_carnival_start_dom = feasts.carnival_start.dom;
   assign rsp_carnival_start_mon = feasts.carnival_start.mon[1:0];
   assign rsp_carnival_end_dom   = feasts.carnival_end.dom;
   assign rsp_carnival_end_mon   = feasts.carnival_end.mon[1:0];
   assign rsp_good_friday_dom    = feasts.good_friday.dom;
   assign rsp_good_friday_mon    = feasts.good_friday.mon;
   assign rsp_ascension_dom      = feasts.ascension.dom;
   assign rsp_ascension_mon      = feasts.ascension.mon;
   assign rsp_whitsun_dom        = feasts.whitsun.dom;
   assign rsp_whitsun_mon        = feasts.whitsun.mon;

   // The input is held off only when every stage is full and the output stalls.
   `EMF_ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall,
      (&v_ff) && rsp_stall, "input stalled with a free stage")
   // A delivered result with nothing behind it leaves the output empty.
   `EMF_ASSERT_NEXT(a_drain, clock, reset,
      rsp_valid && !rsp_stall && !v_ff[NUM_STAGES-2], !rsp_valid,
      "result repeated after delivery")
   // Easter falls in March or April and Whitsuntide in May or June.
   `EMF_ASSERT_IMPLIES(a_month_range, clock, reset, rsp_valid,
      (rsp_easter_mon == MON_MAR || rsp_easter_mon == MON_APR) &&
      (rsp_whitsun_mon == MON_MAY || rsp_whitsun_mon == MON_JUN),
      "feast month out of range")
   // Good Friday leaves the Easter month only when Easter is on day one or two.
   `EMF_ASSERT_IMPLIES(a_friday_month, clock, reset,
      rsp_valid && (rsp_good_friday_mon != rsp_easter_mon), rsp_easter_dom <= 5'd2,
      "good friday month mismatch")

endmodule

// ===== design/emf_div.sv =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: divider front end
// Three stages that split the year into the century, year-in-century and
// golden-number terms and derive the leap-year flag.
// ----------------------------------------------------------------------------
module emf_div (
   input  logic                 clock,
   input  logic [2:0]           stage_en,
   input  logic [15:0]          year,
   output emf_pkg::div_out_type div_out
);
   import emf_pkg::*;

   logic [15:0] year1_ff;
   logic [9:0]  q100_ff;
   logic [11:0] q19_ff;
   logic [28:0] prod100;
   logic [31:0] prod19;

   logic [4:0]  a2_ff;
   logic [9:0]  b2_ff;
   logic [6:0]  c2_ff;
   logic [1:0]  ylo2_ff;
   logic [16:0] r100_full;
   logic [16:0] r19_full;
   logic [7:0]  r100;
   logic [5:0]  r19;
   logic [4:0]  a_in;
   logic [9:0]  b_in;
   logic [6:0]  c_in;

   logic [10:0]  b_plus8;
   logic [16:0]  prod25;
   div_out_type  div_ff;
   div_out_type  div_in;

   // Stage 1: estimated quotients by 100 and by 19.
   assign prod100 = 29'(year) * 29'(RECIP_100);
   assign prod19  = 32'(year) * 32'(RECIP_19);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         year1_ff <= year;
         q100_ff  <= prod100[28:19];
         q19_ff   <= prod19[31:20];
      end
   end

   // Stage 2: remainders with a single correction step each.
   always_comb begin
      r100_full = {1'b0, year1_ff} - 17'(q100_ff) * 17'd100;
      r19_full  = {1'b0, year1_ff} - 17'(q19_ff) * 17'd19;
      r100      = r100_full[7:0];
      r19       = r19_full[5:0];
      if (r100 >= 8'd100) begin
         b_in = q100_ff + 10'd1;
         c_in = 7'(r100 - 8'd100);
      end else begin
         b_in = q100_ff;
         c_in = r100[6:0];
      end
      if (r19 >= 6'd19) begin
         a_in = 5'(r19 - 6'd19);
      end else begin
         a_in = r19[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         a2_ff   <= a_in;
         b2_ff   <= b_in;
         c2_ff   <= c_in;
         ylo2_ff <= year1_ff[1:0];
      end
   end

   // Stage 3: century terms, year-in-century terms and the leap flag.
   always_comb begin
      b_plus8     = 11'(b2_ff) + 11'd8;
      prod25      = 17'(b_plus8) * 17'(RECIP_25);
      div_in.a    = a2_ff;
      div_in.b    = b2_ff;
      div_in.d    = b2_ff[9:2];
      div_in.e    = b2_ff[1:0];
      div_in.f    = prod25[14:10];
      div_in.i    = c2_ff[6:2];
      div_in.k    = c2_ff[1:0];
      div_in.leap = ((ylo2_ff == 2'd0) && (c2_ff != 7'd0)) ||
                    ((c2_ff == 7'd0) && (b2_ff[1:0] == 2'd0));
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         div_ff <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

// ===== design/emf_cpt.sv =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: computus core
// Four stages that take the century, year-in-century and golden-number terms
// to the date of Easter Sunday.
// ----------------------------------------------------------------------------
module emf_cpt (
   input  logic                 clock,
   input  logic [3:0]           stage_en,
   input  emf_pkg::div_out_type div_out,
   output emf_pkg::easter_type  easter
);
   import emf_pkg::*;

   // Stage 4 signals.
   logic [9:0]  gx;
   logic [19:0] prod3;
   logic [9:0]  hs_in;
   logic [7:0]  g4_ff;
   logic [9:0]  hs4_ff;
   logic [4:0]  a4_ff;
   logic [1:0]  e4_ff;
   logic [4:0]  i4_ff;
   logic [1:0]  k4_ff;
   logic        leap4_ff;

   // Stage 5 signals.
   logic [9:0]  hx;
   logic [15:0] prod30;
   logic [5:0]  hr;
   logic [4:0]  h_in;
   logic [4:0]  h5_ff;
   logic [4:0]  a5_ff;
   logic [1:0]  e5_ff;
   logic [4:0]  i5_ff;
   logic [1:0]  k5_ff;
   logic        leap5_ff;

   // Stage 6 signals.
   logic [6:0]  lx;
   logic [12:0] prod7;
   logic [6:0]  lr;
   logic [2:0]  l6_ff;
   logic [4:0]  h6_ff;
   logic [4:0]  a6_ff;
   logic        leap6_ff;

   // Stage 7 signals.
   logic [8:0]  msum;
   logic [7:0]  base;
   easter_type  easter_in;
   easter_type  easter_ff;

   // Stage 4: the g term and the part of the h sum that does not need it.
   always_comb begin
      gx    = div_out.b - 10'(div_out.f) + 10'd1;
      prod3 = 20'(gx) * 20'(RECIP_3);
      hs_in = 10'(div_out.a) * 10'd19 + div_out.b - 10'(div_out.d) + 10'd15;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         g4_ff    <= prod3[18:11];
         hs4_ff   <= hs_in;
         a4_ff    <= div_out.a;
         e4_ff    <= div_out.e;
         i4_ff    <= div_out.i;
         k4_ff    <= div_out.k;
         leap4_ff <= div_out.leap;
      end
   end

   // Stage 5: h is the epact-like sum modulo 30.
   always_comb begin
      hx     = hs4_ff - 10'(g4_ff);
      prod30 = 16'(hx) * 16'(RECIP_30);
      hr     = 6'(hx - 10'(prod30[15:10]) * 10'd30);
      if (hr >= 6'd30) begin
         h_in = 5'(hr - 6'd30);
      end else begin
         h_in = hr[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         h5_ff    <= h_in;
         a5_ff    <= a4_ff;
         e5_ff    <= e4_ff;
         i5_ff    <= i4_ff;
         k5_ff    <= k4_ff;
         leap5_ff <= leap4_ff;
      end
   end

   // Stage 6: l is the weekday correction modulo 7.
   always_comb begin
      lx    = 7'd32 + {4'd0, e5_ff, 1'b0} + {1'b0, i5_ff, 1'b0} - 7'(h5_ff) - 7'(k5_ff);
      prod7 = 13'(lx) * 13'(RECIP_7);
      lr    = lx - 7'(prod7[11:8]) * 7'd7;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         l6_ff    <= lr[2:0];
         h6_ff    <= h5_ff;
         a6_ff    <= a5_ff;
         leap6_ff <= leap5_ff;
      end
   end

   // Stage 7: the m correction, the base value and the Easter date.
   always_comb begin
      msum = 9'(a6_ff) + 9'(h6_ff) * 9'd11 + 9'(l6_ff) * 9'd22;
      base = 8'(h6_ff) + 8'(l6_ff) + 8'd114 - ((msum >= 9'd451) ? 8'd7 : 8'd0);
      if (base >= 8'd124) begin
         easter_in.mon = MON_APR;
         easter_in.dom = 5'(base - 8'd123);
      end else begin
         easter_in.mon = MON_MAR;
         easter_in.dom = 5'(base - 8'd92);
      end
      easter_in.leap = leap6_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         easter_ff <= easter_in;
      end
   end

   assign easter = easter_ff;

endmodule

// ===== design/emf_fst.sv =====
// ----------------------------------------------------------------------------
// Easter and movable feasts: feast stage
// Shifts the Easter date to each feast and holds the result register.
// ----------------------------------------------------------------------------
module emf_fst (
   input  logic                clock,
   input  logic                stage_en,
   input  emf_pkg::easter_type easter,
   output emf_pkg::feasts_type feasts
);
   import emf_pkg::*;

   logic [6:0]        doy;
   logic signed [7:0] doy_s;
   feasts_type        feasts_in;
   feasts_type        feasts_ff;

   // Easter as a day count from March 1, then each feast by its offset.
   always_comb begin
      doy   = (easter.mon == MON_MAR) ? 7'(easter.dom) - 7'd1 : 7'(easter.dom) + 7'd30;
      doy_s = $signed({1'b0, doy});
      feasts_in.easter.dom     = easter.dom;
      feasts_in.easter.mon     = easter.mon;
      feasts_in.carnival_start = to_date(doy_s + CARNIVAL_START_OFS, easter.leap);
      feasts_in.carnival_end   = to_date(doy_s + CARNIVAL_END_OFS, easter.leap);
      feasts_in.good_friday    = to_date(doy_s + GOOD_FRIDAY_OFS, easter.leap);
      feasts_in.ascension      = to_date(doy_s + ASCENSION_OFS, easter.leap);
      feasts_in.whitsun        = to_date(doy_s + WHITSUN_OFS, easter.leap);
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         feasts_ff <= feasts_in;
      end
   end

   assign feasts = feasts_ff;

endmodule
